/* rtl/touch_gesture_classifier_macros.svh */
// assertion macros for the touch gesture classifier
// used by modules that check their own logic; needs clk and arst_n in scope
`ifndef TOUCH_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_MACROS_SVH

// same-cycle implication, checked out of reset
`define TGC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define TGC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/tgc_pkg.sv */
// shared types and constants of the touch gesture classifier
// no dependencies
`default_nettype none

package tgc_pkg;

	localparam int unsigned COORD_W    = 10;
	localparam int unsigned THRESH_W   = 8;
	localparam int unsigned DELTA_W    = 8;
	localparam int unsigned PAGE_W     = 2;
	localparam int unsigned PAGE_COUNT = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	typedef logic [COORD_W-1:0]       coord_t;
	typedef logic [THRESH_W-1:0]      thresh_t;
	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic [PAGE_W-1:0]        page_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]    cfg_data_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_MOVE  = 2'd1,
		EV_CLICK = 2'd2,
		EV_PAGE  = 2'd3
	} event_kind_t;

	localparam cfg_idx_t REG_PAD_LIMIT   = 3'd0;
	localparam cfg_idx_t REG_DRAG_THRESH = 3'd1;
	localparam cfg_idx_t REG_SWIPE_MIN_X = 3'd2;
	localparam cfg_idx_t REG_SWIPE_MAX_Y = 3'd3;

	localparam coord_t  PAD_LIMIT_RST   = 10'd320;
	localparam thresh_t DRAG_THRESH_RST = 8'd8;
	localparam coord_t  SWIPE_MIN_X_RST = 10'd40;
	localparam coord_t  SWIPE_MAX_Y_RST = 10'd20;

	localparam page_t PAGE_LAST = PAGE_W'(PAGE_COUNT - 1);

endpackage

`default_nettype wire

/* rtl/tgc_if.sv */
// valid/ready channel interfaces: touch samples in, gesture events out
// depends on tgc_pkg
`default_nettype none

interface tgc_sample_if;
	import tgc_pkg::*;

	logic   valid;
	logic   ready;
	logic   pressed;
	coord_t sample_x;
	coord_t sample_y;
	logic   link_up;

	modport source (output valid, pressed, sample_x, sample_y, link_up, input ready);
	modport sink   (input valid, pressed, sample_x, sample_y, link_up, output ready);
endinterface

interface tgc_event_if;
	import tgc_pkg::*;

	logic        valid;
	logic        ready;
	event_kind_t event_kind;
	delta_t      delta_x;
	delta_t      delta_y;
	page_t       page_index;

	modport source (output valid, event_kind, delta_x, delta_y, page_index, input ready);
	modport sink   (input valid, event_kind, delta_x, delta_y, page_index, output ready);
endinterface

`default_nettype wire

/* rtl/touch_gesture_classifier.sv */
// touch gesture classifier top level: sample register, gesture decision, result register
// depends on tgc_pkg, tgc_if and touch_gesture_classifier_macros.svh
`default_nettype none
`include "touch_gesture_classifier_macros.svh"

// Turns a stream of touch samples into pointer events, one result beat for every
// sample beat. A sample is a press only when pressed is set and sample_y is below
// pad_limit; anything else is a release. The first press of a touch latches the
// start point; moving more than drag_threshold from it on either axis marks a drag.
// While dragging with the link up, a press with nonzero motion gives a relative
// move (deltas wrapped to 8 bits); on release with the link up an undragged touch
// gives a click, and a dragged touch that travelled more than swipe_min_x across
// and less than swipe_max_y up or down advances the page counter (modulo 3) and
// gives a page event. Throughput is one sample per clock while result beats are
// taken; each accepted sample beat passes through the sample register, then the
// result register, to its result beat. The touch state closes its loop through
// the decision logic, so back-to-back samples see each other's effects. While the
// result register holds a beat that has not been taken, it and the touch state
// hold; the sample register still takes one more beat if it is empty, and then
// input ready drops. Configuration writes are meant to happen while no sample
// is in flight.
module touch_gesture_classifier (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  tgc_pkg::cfg_idx_t   cfg_index,
	input  tgc_pkg::cfg_data_t  cfg_data,
	tgc_sample_if.sink          touch,
	tgc_event_if.source         gest
);
	import tgc_pkg::*;

	// absolute difference of two coordinates
	function automatic coord_t abs_diff(input coord_t a, input coord_t b);
		abs_diff = (a > b) ? coord_t'(a - b) : coord_t'(b - a);
	endfunction

	// configuration registers
	coord_t  pad_limit_q;
	thresh_t drag_thresh_q;
	coord_t  swipe_min_x_q;
	coord_t  swipe_max_y_q;

	// touch state
	logic   prev_valid_q;
	logic   dragging_q;
	coord_t prev_x_q;
	coord_t prev_y_q;
	coord_t start_x_q;
	coord_t start_y_q;
	page_t  page_q;

	// sample register
	logic   valid_s1;
	logic   pressed_s1;
	coord_t x_s1;
	coord_t y_s1;
	logic   link_s1;

	// result register
	logic        valid_s2;
	event_kind_t kind_s2;
	delta_t      dx_s2;
	delta_t      dy_s2;
	page_t       page_s2;

	// decision logic
	logic        advance;
	logic        is_press;
	logic        drag_hit;
	logic        dragging_n;
	coord_t      start_x_n;
	coord_t      start_y_n;
	delta_t      mx;
	delta_t      my;
	logic        is_swipe;
	page_t       page_n;
	event_kind_t kind_n;
	delta_t      dx_n;
	delta_t      dy_n;

	// the whole pipe moves whenever the result register is free or being drained
	assign advance     = !valid_s2 || gest.ready;
	assign touch.ready = !valid_s1 || advance;

	// config write port, out-of-range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_limit_q   <= PAD_LIMIT_RST;
			drag_thresh_q <= DRAG_THRESH_RST;
			swipe_min_x_q <= SWIPE_MIN_X_RST;
			swipe_max_y_q <= SWIPE_MAX_Y_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PAD_LIMIT:   pad_limit_q   <= cfg_data;
				REG_DRAG_THRESH: drag_thresh_q <= cfg_data[THRESH_W-1:0];
				REG_SWIPE_MIN_X: swipe_min_x_q <= cfg_data;
				REG_SWIPE_MAX_Y: swipe_max_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sample register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (touch.ready) begin
			valid_s1 <= touch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (touch.valid && touch.ready) begin
			pressed_s1 <= touch.pressed;
			x_s1       <= touch.sample_x;
			y_s1       <= touch.sample_y;
			link_s1    <= touch.link_up;
		end
	end

	always_comb begin
		is_press = pressed_s1 && (y_s1 < pad_limit_q);

		// first press of a touch restarts from this point with no drag
		start_x_n = prev_valid_q ? start_x_q : x_s1;
		start_y_n = prev_valid_q ? start_y_q : y_s1;
		drag_hit  = (abs_diff(x_s1, start_x_q) > {2'b00, drag_thresh_q}) ||
		            (abs_diff(y_s1, start_y_q) > {2'b00, drag_thresh_q});
		dragging_n = prev_valid_q && (dragging_q || drag_hit);

		// motion since last press, wrapped to the delta width
		mx = delta_t'(x_s1 - prev_x_q);
		my = delta_t'(y_s1 - prev_y_q);

		// swipe is judged on the last press of the touch
		is_swipe = (abs_diff(prev_x_q, start_x_q) > swipe_min_x_q) &&
		           (abs_diff(prev_y_q, start_y_q) < swipe_max_y_q);

		kind_n = EV_NONE;
		dx_n   = '0;
		dy_n   = '0;
		page_n = page_q;
		if (is_press) begin
			if (dragging_n && link_s1 && ((mx != '0) || (my != '0))) begin
				kind_n = EV_MOVE;
				dx_n   = mx;
				dy_n   = my;
			end
		end else if (prev_valid_q && link_s1) begin
			if (!dragging_q) begin
				kind_n = EV_CLICK;
			end else if (is_swipe) begin
				kind_n = EV_PAGE;
				page_n = (page_q == PAGE_LAST) ? '0 : page_t'(page_q + 1'b1);
			end
		end
	end

	// touch state follows each sample as it moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_valid_q <= 1'b0;
			dragging_q   <= 1'b0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			start_x_q    <= '0;
			start_y_q    <= '0;
			page_q       <= '0;
		end else if (valid_s1 && advance) begin
			page_q <= page_n;
			if (is_press) begin
				prev_valid_q <= 1'b1;
				dragging_q   <= dragging_n;
				start_x_q    <= start_x_n;
				start_y_q    <= start_y_n;
				prev_x_q     <= x_s1;
				prev_y_q     <= y_s1;
			end else begin
				// drag mark is kept until the next touch starts
				prev_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			kind_s2 <= kind_n;
			dx_s2   <= dx_n;
			dy_s2   <= dy_n;
			page_s2 <= page_n;
		end
	end

	assign gest.valid      = valid_s2;
	assign gest.event_kind = kind_s2;
	assign gest.delta_x    = dx_s2;
	assign gest.delta_y    = dy_s2;
	assign gest.page_index = page_s2;

	`TGC_ASSERT_NOW(a_move_nonzero, valid_s2 && (kind_s2 == EV_MOVE), (dx_s2 != '0) || (dy_s2 != '0), "move beat with zero motion")
	`TGC_ASSERT_NOW(a_still_zero, valid_s2 && (kind_s2 != EV_MOVE), (dx_s2 == '0) && (dy_s2 == '0), "non-move beat carries motion")
	`TGC_ASSERT_NOW(a_page_range, 1'b1, page_q <= PAGE_LAST, "page counter out of range")
	`TGC_ASSERT_NEXT(a_page_hold, !(valid_s1 && advance && (kind_n == EV_PAGE)), $stable(page_q), "page counter moved without a page event")

endmodule

`default_nettype wire
